// File: rtl/crps_pkg.sv
`timescale 1ns / 1ps
// Package for the Catmull-Rom path smoother: widths, command and status types,
// back-end state codes. No dependencies.
package crps_pkg;
  localparam int COORD_BITS = 32;
  localparam int STEP_BITS  = 5;
  localparam int MAX_STEPS  = 31;
  localparam int LAYER_BITS = 4;
  localparam int DATA_BITS  = 3 * COORD_BITS;
  localparam int QDEPTH     = 2;
  localparam int PTR_BITS   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
  localparam int SQ_BITS    = 2 * STEP_BITS;
  localparam int CU_BITS    = 3 * STEP_BITS;
  localparam int WCALC_BITS = 3 * STEP_BITS + 5;
  localparam int W_BITS     = 3 * STEP_BITS + 3;
  localparam int DEN_BITS   = 3 * STEP_BITS + 1;
  localparam int PROD_BITS  = COORD_BITS + W_BITS;
  localparam int ACC_BITS   = PROD_BITS + 3;
  localparam int CNT_BITS   = $clog2(ACC_BITS);
  localparam int CFG_ADDR_BITS = 1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEPS = '0;
  localparam logic [STEP_BITS-1:0] STEPS_RESET = STEP_BITS'(4);

  typedef logic [2:0][COORD_BITS-1:0] point_t;

  typedef enum logic {
    CMD_POINT,
    CMD_SEG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    point_t [3:0]           p;
    logic [LAYER_BITS-1:0]  layer;
    logic                   path_end;
    logic [STEP_BITS-1:0]   steps;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP1,
    B_PREP2,
    B_WGT,
    B_MAC,
    B_DSET,
    B_DIV,
    B_OUT
  } back_state_t;
endpackage

// File: rtl/catmull_rom_path_smoother_unit.sv
`timescale 1ns / 1ps
// Top level of the Catmull-Rom path smoother: config register, front end,
// command queue, back end. Depends on crps_pkg, crps_front, crps_fifo, crps_back.
//
//  channel | ports      | moves
//  --------+------------+-----------------------------------------------
//  input   | in_t*      | one path point per item, tlast on final point
//  output  | out_t*     | passed points and spline samples
//  config  | cfg_p*     | APB, smoothing_steps at address 0
//
// A passed point skips the arithmetic; each spline sample is computed by the
// bit-serial divider that the three coordinate lanes run in parallel. An item
// yields up to 2N samples.
// Reset is synchronous: window, counters, queue and output valid clear.
// The front takes a new point once its commands are pushed into the queue; a
// stalled output holds the back end, and the front too once the queue is full.
module catmull_rom_path_smoother_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [crps_pkg::DATA_BITS-1:0]      in_tdata,  // x_coord, y_coord, z_coord
  input  logic [crps_pkg::LAYER_BITS-1:0]     in_tuser,  // layer_tag
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [crps_pkg::DATA_BITS-1:0]      out_tdata, // x_out, y_out, z_out
  output logic [crps_pkg::LAYER_BITS-1:0]     out_tuser, // layer_out
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [crps_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import crps_pkg::*;

  logic [STEP_BITS-1:0] steps_r;
  q_stat_t              q_stat;
  logic                 q_push, q_pop;
  cmd_t                 push_cmd, pop_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_STEPS) ? 32'(steps_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_STEPS) begin
      steps_r <= cfg_pwdata[STEP_BITS-1:0];
    end
  end

  crps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .steps     (steps_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  crps_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .pop     (q_pop),
    .cmd_out (pop_cmd),
    .stat    (q_stat)
  );

  crps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("input ready dropped without an accepted item");
endmodule

// File: rtl/crps_front.sv
`timescale 1ns / 1ps
// Front end: accepts points, keeps the control-point window, issues commands.
// Depends on crps_pkg.
module crps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [crps_pkg::STEP_BITS-1:0] steps,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [crps_pkg::DATA_BITS-1:0] in_tdata,  // x_coord, y_coord, z_coord
  input  logic [crps_pkg::LAYER_BITS-1:0] in_tuser, // layer_tag
  input  logic                           in_tlast,
  input  crps_pkg::q_stat_t              q_stat,
  output logic                           q_push,
  output crps_pkg::cmd_t                 q_cmd
);
  import crps_pkg::*;

  point_t                win_r [3];
  logic [LAYER_BITS-1:0] wlay_r [3];
  logic [1:0]            seen_r;
  logic                  pend_r;
  logic [2:0]            todo_r;
  point_t                s_win_r [3];
  logic [LAYER_BITS-1:0] s_wlay_r [3];
  point_t                cur_r;
  logic [LAYER_BITS-1:0] lay_r;
  logic                  last_r;
  logic [STEP_BITS-1:0]  n_r;

  logic                  acc;
  logic [STEP_BITS-1:0]  n_eff;
  logic [2:0]            todo_new;
  logic [2:0]            todo_nxt;
  point_t                cur;

  assign cur       = point_t'(in_tdata);
  assign in_tready = !pend_r;
  assign acc       = in_tvalid && !pend_r;
  assign n_eff     = (steps > STEP_BITS'(MAX_STEPS)) ? STEP_BITS'(MAX_STEPS) : steps;
  assign q_push    = pend_r && !q_stat.full;

  always_comb begin
    todo_new = 3'b000;
    if (seen_r == 2'd0 || n_eff == '0) begin
      todo_new[2] = 1'b1;
    end else begin
      todo_new[0] = (seen_r >= 2'd2);
      todo_new[1] = in_tlast && (seen_r >= 2'd2);
      todo_new[2] = in_tlast;
    end
  end

  always_comb begin
    q_cmd          = '0;
    q_cmd.steps    = n_r;
    todo_nxt       = todo_r;
    priority if (todo_r[0]) begin
      q_cmd.kind  = CMD_SEG;
      q_cmd.p[0]  = s_win_r[0];
      q_cmd.p[1]  = s_win_r[1];
      q_cmd.p[2]  = s_win_r[2];
      q_cmd.p[3]  = cur_r;
      q_cmd.layer = s_wlay_r[1];
      todo_nxt[0] = 1'b0;
    end else if (todo_r[1]) begin
      q_cmd.kind  = CMD_SEG;
      q_cmd.p[0]  = s_win_r[1];
      q_cmd.p[1]  = s_win_r[2];
      q_cmd.p[2]  = cur_r;
      q_cmd.p[3]  = cur_r;
      q_cmd.layer = s_wlay_r[2];
      todo_nxt[1] = 1'b0;
    end else begin
      q_cmd.kind     = CMD_POINT;
      q_cmd.p[0]     = cur_r;
      q_cmd.layer    = lay_r;
      q_cmd.path_end = last_r;
      todo_nxt[2]    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pend_r <= 1'b0;
      todo_r <= '0;
      for (int k = 0; k < 3; k++) begin
        win_r[k]  <= '0;
        wlay_r[k] <= '0;
      end
    end else if (acc) begin
      s_win_r  <= win_r;
      s_wlay_r <= wlay_r;
      cur_r    <= cur;
      lay_r    <= in_tuser;
      last_r   <= in_tlast;
      n_r      <= n_eff;
      todo_r   <= todo_new;
      pend_r   <= |todo_new;
      if (seen_r == 2'd0) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k]  <= cur;
          wlay_r[k] <= in_tuser;
        end
      end else begin
        win_r[0]  <= win_r[1];
        win_r[1]  <= win_r[2];
        win_r[2]  <= cur;
        wlay_r[0] <= wlay_r[1];
        wlay_r[1] <= wlay_r[2];
        wlay_r[2] <= in_tuser;
      end
      if (in_tlast) begin
        seen_r <= '0;
      end else if (seen_r != 2'd3) begin
        seen_r <= seen_r + 2'd1;
      end
    end else if (q_push) begin
      todo_r <= todo_nxt;
      pend_r <= |todo_nxt;
    end
  end
endmodule

// File: rtl/crps_fifo.sv
`timescale 1ns / 1ps
// Command queue between front and back end.
// Depends on crps_pkg.
module crps_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  crps_pkg::cmd_t    cmd_in,
  input  logic              pop,
  output crps_pkg::cmd_t    cmd_out,
  output crps_pkg::q_stat_t stat
);
  import crps_pkg::*;

  cmd_t                 mem_r [QDEPTH];
  logic [PTR_BITS-1:0]  wp_r;
  logic [PTR_BITS-1:0]  rp_r;
  logic [QCNT_BITS-1:0] cnt_r;

  assign stat.full  = (cnt_r == QCNT_BITS'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign cmd_out    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_BITS'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_BITS'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

// File: rtl/crps_back.sv
`timescale 1ns / 1ps
// Back end: runs commands, computes Catmull-Rom samples with a per-lane MAC
// and bit-serial divider, drives the output register. Depends on crps_pkg.
module crps_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crps_pkg::q_stat_t               q_stat,
  input  crps_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [crps_pkg::DATA_BITS-1:0]  out_tdata,  // x_out, y_out, z_out
  output logic [crps_pkg::LAYER_BITS-1:0] out_tuser,  // layer_out
  output logic                            out_tlast
);
  import crps_pkg::*;

  localparam logic signed [ACC_BITS:0] SAT_HI =
    $signed({{(ACC_BITS - COORD_BITS + 2){1'b0}}, {(COORD_BITS - 1){1'b1}}});
  localparam logic signed [ACC_BITS:0] SAT_LO = -SAT_HI - 1;

  typedef logic signed [WCALC_BITS-1:0] wc_t;

  back_state_t                 state_r, state_nxt;
  cmd_t                        cmd_r;
  logic [STEP_BITS-1:0]        i_r;
  logic [CNT_BITS-1:0]         cnt_r;
  logic [SQ_BITS-1:0]          i2_r, n2_r;
  logic [CU_BITS-1:0]          i3_r, n3_r, a_r, b_r;
  logic signed [W_BITS-1:0]    w_r [4];
  logic signed [PROD_BITS-1:0] prod_r [3];
  logic signed [ACC_BITS-1:0]  acc_r [3];
  logic [ACC_BITS-1:0]         dvd_r [3];
  logic [ACC_BITS-1:0]         quo_r [3];
  logic [DEN_BITS-1:0]         rem_r [3];
  logic                        neg_r [3];
  logic                        out_v_r;
  logic [DATA_BITS-1:0]        out_data_r;
  logic [LAYER_BITS-1:0]       out_user_r;
  logic                        out_last_r;

  logic                        slot_free;
  logic                        load_out;
  logic [DEN_BITS-1:0]         den;
  wc_t                         ac, bc, i3c, n3c;
  point_t                      sat_pt;

  assign slot_free  = !out_v_r || out_tready;
  assign den        = {n3_r, 1'b0};
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign ac  = wc_t'(a_r);
  assign bc  = wc_t'(b_r);
  assign i3c = wc_t'(i3_r);
  assign n3c = wc_t'(n3_r);

  always_comb begin
    logic signed [ACC_BITS:0] qs;
    for (int c = 0; c < 3; c++) begin
      qs = neg_r[c] ? -$signed({1'b0, quo_r[c]}) : $signed({1'b0, quo_r[c]});
      if (qs > SAT_HI) begin
        sat_pt[c] = COORD_BITS'(SAT_HI);
      end else if (qs < SAT_LO) begin
        sat_pt[c] = COORD_BITS'(SAT_LO);
      end else begin
        sat_pt[c] = COORD_BITS'(qs);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = (q_cmd.kind == CMD_SEG) ? B_PREP1 : B_OUT;
        end
      end
      B_PREP1: state_nxt = B_PREP2;
      B_PREP2: state_nxt = B_WGT;
      B_WGT:   state_nxt = B_MAC;
      B_MAC: begin
        if (cnt_r == CNT_BITS'(4)) state_nxt = B_DSET;
      end
      B_DSET:  state_nxt = B_DIV;
      B_DIV: begin
        if (cnt_r == CNT_BITS'(ACC_BITS - 1)) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = (cmd_r.kind == CMD_SEG && i_r != cmd_r.steps) ? B_PREP1 : B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ACC_BITS-1:0] x;
    logic [DEN_BITS:0]          r2;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          cmd_r <= q_cmd;
          i_r   <= STEP_BITS'(1);
        end
      end
      B_PREP1: begin
        i2_r  <= SQ_BITS'(i_r) * SQ_BITS'(i_r);
        n2_r  <= SQ_BITS'(cmd_r.steps) * SQ_BITS'(cmd_r.steps);
        cnt_r <= '0;
      end
      B_PREP2: begin
        i3_r <= CU_BITS'(i2_r) * CU_BITS'(i_r);
        n3_r <= CU_BITS'(n2_r) * CU_BITS'(cmd_r.steps);
        a_r  <= CU_BITS'(n2_r) * CU_BITS'(i_r);
        b_r  <= CU_BITS'(i2_r) * CU_BITS'(cmd_r.steps);
      end
      B_WGT: begin
        w_r[0] <= W_BITS'(-ac + 2 * bc - i3c);
        w_r[1] <= W_BITS'(2 * n3c - 5 * bc + 3 * i3c);
        w_r[2] <= W_BITS'(ac + 4 * bc - 3 * i3c);
        w_r[3] <= W_BITS'(i3c - bc);
        for (int c = 0; c < 3; c++) acc_r[c] <= '0;
      end
      B_MAC: begin
        for (int c = 0; c < 3; c++) begin
          if (cnt_r != CNT_BITS'(4)) begin
            prod_r[c] <= w_r[cnt_r[1:0]] * $signed(cmd_r.p[cnt_r[1:0]][c]);
          end
          if (cnt_r != '0) begin
            acc_r[c] <= acc_r[c] + ACC_BITS'(prod_r[c]);
          end
        end
        cnt_r <= cnt_r + 1'b1;
      end
      B_DSET: begin
        for (int c = 0; c < 3; c++) begin
          x = acc_r[c] + $signed(ACC_BITS'(n3_r));
          neg_r[c] <= x[ACC_BITS-1];
          dvd_r[c] <= x[ACC_BITS-1] ? ACC_BITS'(-x + $signed(ACC_BITS'(den)) - 1)
                                    : ACC_BITS'(x);
          rem_r[c] <= '0;
        end
        cnt_r <= '0;
      end
      B_DIV: begin
        for (int c = 0; c < 3; c++) begin
          r2 = {rem_r[c], dvd_r[c][ACC_BITS-1]};
          dvd_r[c] <= dvd_r[c] << 1;
          if (r2 >= {1'b0, den}) begin
            rem_r[c] <= DEN_BITS'(r2 - {1'b0, den});
            quo_r[c] <= {quo_r[c][ACC_BITS-2:0], 1'b1};
          end else begin
            rem_r[c] <= DEN_BITS'(r2);
            quo_r[c] <= {quo_r[c][ACC_BITS-2:0], 1'b0};
          end
        end
        cnt_r <= cnt_r + 1'b1;
      end
      B_OUT: begin
        if (load_out) i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_user_r <= cmd_r.layer;
      if (cmd_r.kind == CMD_SEG) begin
        out_data_r <= DATA_BITS'(sat_pt);
        out_last_r <= 1'b0;
      end else begin
        out_data_r <= DATA_BITS'(cmd_r.p[0]);
        out_last_r <= cmd_r.path_end;
      end
    end
  end
endmodule
